>>> design/rpnh_pkg.sv
// ----------------------------------------------------------------------------
// rpnh_pkg
// Types, widths and helpers shared by the ray / polygon nearest hit core.
// ----------------------------------------------------------------------------
package rpnh_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int HALF_W    = DIFF_W;
  localparam int MAG_W     = 2 * HALF_W;
  localparam int MUL_W     = HALF_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CROSS_W   = MAG_W + 1;
  localparam int ACC_W     = 2 * MAG_W + 4;
  localparam int DIV_W     = MAG_W + DIFF_W + FRAC_BITS + 2;
  localparam int OUT_W     = 24;
  localparam int STEP_W    = $clog2(DIV_W + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] ray_start_x;
    logic signed [COORD_W-1:0] ray_start_y;
    logic signed [COORD_W-1:0] ray_end_x;
    logic signed [COORD_W-1:0] ray_end_y;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] hit_x;
    logic signed [OUT_W-1:0] hit_y;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rsx;
    logic signed [COORD_W-1:0] rsy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DIFF_W-1:0]  ex;
    logic signed [DIFF_W-1:0]  ey;
    logic signed [DIFF_W-1:0]  delx;
    logic signed [DIFF_W-1:0]  dely;
    logic                      fresh;
    logic                      last;
  } edge_job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_ctl_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_EDGE,
    B_NORM,
    B_CMP,
    B_DECIDE,
    B_FIN,
    B_PT,
    B_DIVSET,
    B_DIV,
    B_SAT,
    B_EMIT
  } back_state_t;

  function automatic logic signed [DIFF_W-1:0] sub_ext(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] ae;
    logic signed [DIFF_W-1:0] be;
    ae = {a[COORD_W-1], a};
    be = {b[COORD_W-1], b};
    return ae - be;
  endfunction

  function automatic edge_job_t make_job(
    input in_item_t                  it,
    input logic signed [COORD_W-1:0] ax,
    input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] bx,
    input logic signed [COORD_W-1:0] by,
    input logic                      fresh,
    input logic                      last
  );
    edge_job_t j;
    j.rsx   = it.ray_start_x;
    j.rsy   = it.ray_start_y;
    j.dx    = sub_ext(it.ray_end_x, it.ray_start_x);
    j.dy    = sub_ext(it.ray_end_y, it.ray_start_y);
    j.ex    = sub_ext(bx, ax);
    j.ey    = sub_ext(by, ay);
    j.delx  = sub_ext(ax, it.ray_start_x);
    j.dely  = sub_ext(ay, it.ray_start_y);
    j.fresh = fresh;
    j.last  = last;
    return j;
  endfunction

endpackage

>>> design/rpnh_front.sv
// ----------------------------------------------------------------------------
// rpnh_front
// Accepts vertex transactions, tracks polygon state, emits edge jobs.
// ----------------------------------------------------------------------------
module rpnh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  rpnh_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                q_push,
  output rpnh_pkg::edge_job_t q_job,
  input  logic                q_full
);

  logic                              in_poly_r;
  logic                              fresh_r;
  logic                              pend_valid_r;
  rpnh_pkg::edge_job_t               pend_job_r;
  logic signed [rpnh_pkg::COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                              take;

  assign in_full = pend_valid_r | q_full;
  assign take    = in_push & ~in_full;

  always_comb begin
    q_push = 1'b0;
    q_job  = pend_job_r;
    if (pend_valid_r) begin
      q_push = ~q_full;
    end else if (take) begin
      if (in_poly_r) begin
        q_push = 1'b1;
        q_job  = rpnh_pkg::make_job(in_item, prev_x_r, prev_y_r,
                                    in_item.vertex_x, in_item.vertex_y, fresh_r, 1'b0);
      end else if (in_item.last_vertex) begin
        q_push = 1'b1;
        q_job  = rpnh_pkg::make_job(in_item, in_item.vertex_x, in_item.vertex_y,
                                    in_item.vertex_x, in_item.vertex_y, 1'b1, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_poly_r    <= 1'b0;
      fresh_r      <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (pend_valid_r && !q_full) begin
        pend_valid_r <= 1'b0;
      end
      if (take) begin
        if (!in_poly_r) begin
          in_poly_r <= ~in_item.last_vertex;
          fresh_r   <= 1'b1;
        end else begin
          fresh_r <= 1'b0;
          if (in_item.last_vertex) begin
            in_poly_r    <= 1'b0;
            pend_valid_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_x_r <= in_item.vertex_x;
      prev_y_r <= in_item.vertex_y;
      if (!in_poly_r) begin
        first_x_r <= in_item.vertex_x;
        first_y_r <= in_item.vertex_y;
      end else if (in_item.last_vertex) begin
        pend_job_r <= rpnh_pkg::make_job(in_item, in_item.vertex_x, in_item.vertex_y,
                                         first_x_r, first_y_r, 1'b0, 1'b1);
      end
    end
  end

endmodule

>>> design/rpnh_queue.sv
// ----------------------------------------------------------------------------
// rpnh_queue
// Short edge job queue between front and back.
// ----------------------------------------------------------------------------
module rpnh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  rpnh_pkg::q_wr_ctl_t wr_ctl,
  input  rpnh_pkg::edge_job_t wr_job,
  output logic                full,
  input  logic                pop,
  output rpnh_pkg::edge_job_t rd_job,
  output logic                empty
);

  rpnh_pkg::edge_job_t              mem [rpnh_pkg::QDEPTH];
  logic [rpnh_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [rpnh_pkg::QCNT_W-1:0]      count_r;
  logic                             do_wr, do_rd;

  assign full   = (count_r == rpnh_pkg::QCNT_W'(rpnh_pkg::QDEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_ctl.push & ~full;
  assign do_rd  = pop & ~empty;
  assign rd_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ctl.push |-> !wr_ctl.full)
    else $error("edge job pushed into a full queue");
`endif

endmodule

>>> design/rpnh_back.sv
// ----------------------------------------------------------------------------
// rpnh_back
// Exact edge test, nearest hit by cross-multiplication, hit point division.
// ----------------------------------------------------------------------------
module rpnh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rpnh_pkg::edge_job_t q_job,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output rpnh_pkg::out_item_t out_item
);

  localparam int HW = rpnh_pkg::HALF_W;
  localparam int CW = rpnh_pkg::CROSS_W;
  localparam int MW = rpnh_pkg::MAG_W;
  localparam int AW = rpnh_pkg::ACC_W;
  localparam int DW = rpnh_pkg::DIV_W;
  localparam int SW = rpnh_pkg::STEP_W;
  localparam int OW = rpnh_pkg::OUT_W;

  rpnh_pkg::back_state_t state_r, state_nxt;
  logic [SW-1:0]              step_r;
  rpnh_pkg::edge_job_t        job_r;
  logic                       found_r;
  logic [MW-1:0]              bn_r, bd_r;
  logic signed [CW-1:0]       den_r, un_r, tn_r;
  logic signed [rpnh_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0]       acc_r;
  logic                       coord_r;
  logic                       neg_r;
  logic [MW-1:0]              rem_r;
  logic [DW-1:0]              quo_r;
  logic signed [OW-1:0]       hx_r, hy_r;
  logic                       out_valid_r;
  rpnh_pkg::out_item_t        out_item_r;

  logic signed [rpnh_pkg::MUL_W-1:0] mul_a, mul_b;
  logic                       out_wr;
  logic [2:0]                 kk;
  logic signed [AW-1:0]       term;
  logic [5:0]                 sh;
  logic                       nneg;
  logic signed [CW-1:0]       nd, nu, nt;
  logic                       hit_ok;
  logic [MW-1:0]              cmp_a, cmp_b;
  logic signed [rpnh_pkg::COORD_W-1:0] pt_start;
  logic signed [rpnh_pkg::DIFF_W-1:0]  pt_dir;
  logic signed [AW-1:0]       num_w, mag_w;
  logic [MW:0]                div_sh;
  logic                       div_ge;
  logic signed [OW-1:0]       sat_v;

  assign kk        = 3'(step_r - 1'b1);
  assign out_empty = ~out_valid_r;
  assign out_item  = out_item_r;
  assign prod_nxt  = mul_a * mul_b;

  // edge normalization and hit test
  always_comb begin
    nneg   = den_r[CW-1];
    nd     = nneg ? -den_r : den_r;
    nu     = nneg ? -un_r  : un_r;
    nt     = nneg ? -tn_r  : tn_r;
    hit_ok = (nd != '0) && !nu[CW-1] && (nt > 0) && (nt < nd);
  end

  // shifted product for accumulation
  always_comb begin
    sh = '0;
    if (state_r == rpnh_pkg::B_CMP) begin
      case ({1'b0, kk[1]} + {1'b0, kk[0]})
        2'd1:    sh = 6'(HW);
        2'd2:    sh = 6'(2 * HW);
        default: sh = '0;
      endcase
    end else if (kk[0]) begin
      sh = 6'(HW);
    end
    term = AW'(prod_r) <<< sh;
  end

  always_comb begin
    pt_start = coord_r ? job_r.rsy : job_r.rsx;
    pt_dir   = coord_r ? job_r.dy  : job_r.dx;
    num_w    = acc_r <<< rpnh_pkg::FRAC_BITS;
    mag_w    = acc_r[AW-1] ? -num_w : num_w;
    div_sh   = {rem_r, quo_r[DW-1]};
    div_ge   = (div_sh >= {1'b0, bd_r});
    if (neg_r) begin
      sat_v = (quo_r > DW'(1 << (OW - 1))) ? {1'b1, {(OW-1){1'b0}}} : -quo_r[OW-1:0];
    end else begin
      sat_v = (quo_r > DW'((1 << (OW - 1)) - 1)) ? {1'b0, {(OW-1){1'b1}}} : quo_r[OW-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpnh_pkg::B_IDLE:   if (!q_empty) state_nxt = rpnh_pkg::B_EDGE;
      rpnh_pkg::B_EDGE:   if (step_r == SW'(6)) state_nxt = rpnh_pkg::B_NORM;
      rpnh_pkg::B_NORM: begin
        if (hit_ok && found_r) begin
          state_nxt = rpnh_pkg::B_CMP;
        end else begin
          state_nxt = job_r.last ? rpnh_pkg::B_FIN : rpnh_pkg::B_IDLE;
        end
      end
      rpnh_pkg::B_CMP:    if (step_r == SW'(8)) state_nxt = rpnh_pkg::B_DECIDE;
      rpnh_pkg::B_DECIDE: state_nxt = job_r.last ? rpnh_pkg::B_FIN : rpnh_pkg::B_IDLE;
      rpnh_pkg::B_FIN:    state_nxt = found_r ? rpnh_pkg::B_PT : rpnh_pkg::B_EMIT;
      rpnh_pkg::B_PT:     if (step_r == SW'(4)) state_nxt = rpnh_pkg::B_DIVSET;
      rpnh_pkg::B_DIVSET: state_nxt = rpnh_pkg::B_DIV;
      rpnh_pkg::B_DIV:    if (step_r == SW'(DW - 1)) state_nxt = rpnh_pkg::B_SAT;
      rpnh_pkg::B_SAT:    state_nxt = coord_r ? rpnh_pkg::B_EMIT : rpnh_pkg::B_PT;
      rpnh_pkg::B_EMIT:   if (!out_valid_r) state_nxt = rpnh_pkg::B_IDLE;
      default:            state_nxt = rpnh_pkg::B_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    q_pop  = (state_r == rpnh_pkg::B_IDLE) && !q_empty;
    out_wr = (state_r == rpnh_pkg::B_EMIT) && !out_valid_r;
    mul_a  = '0;
    mul_b  = '0;
    cmp_a  = step_r[2] ? bn_r : un_r[MW-1:0];
    cmp_b  = step_r[2] ? den_r[MW-1:0] : bd_r;
    case (state_r)
      rpnh_pkg::B_EDGE: begin
        case (step_r)
          SW'(0): begin mul_a = {job_r.dx[HW-1], job_r.dx};     mul_b = {job_r.ey[HW-1], job_r.ey}; end
          SW'(1): begin mul_a = {job_r.dy[HW-1], job_r.dy};     mul_b = {job_r.ex[HW-1], job_r.ex}; end
          SW'(2): begin mul_a = {job_r.delx[HW-1], job_r.delx}; mul_b = {job_r.ey[HW-1], job_r.ey}; end
          SW'(3): begin mul_a = {job_r.dely[HW-1], job_r.dely}; mul_b = {job_r.ex[HW-1], job_r.ex}; end
          SW'(4): begin mul_a = {job_r.delx[HW-1], job_r.delx}; mul_b = {job_r.dy[HW-1], job_r.dy}; end
          SW'(5): begin mul_a = {job_r.dely[HW-1], job_r.dely}; mul_b = {job_r.dx[HW-1], job_r.dx}; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      rpnh_pkg::B_CMP: begin
        mul_a = {1'b0, step_r[1] ? cmp_a[MW-1:HW] : cmp_a[HW-1:0]};
        mul_b = {1'b0, step_r[0] ? cmp_b[MW-1:HW] : cmp_b[HW-1:0]};
      end
      rpnh_pkg::B_PT: begin
        if (!step_r[1]) begin
          mul_a = {{2{pt_start[rpnh_pkg::COORD_W-1]}}, pt_start};
          mul_b = {1'b0, step_r[0] ? bd_r[MW-1:HW] : bd_r[HW-1:0]};
        end else begin
          mul_a = {pt_dir[HW-1], pt_dir};
          mul_b = {1'b0, step_r[0] ? bn_r[MW-1:HW] : bn_r[HW-1:0]};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpnh_pkg::B_IDLE;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? '0 : step_r + 1'b1;
      if (out_wr) begin
        out_valid_r <= 1'b1;
        found_r     <= 1'b0;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && q_job.fresh) begin
        found_r <= 1'b0;
      end
      if (state_r == rpnh_pkg::B_NORM && hit_ok && !found_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (q_pop) begin
      job_r <= q_job;
    end
    if (out_wr) begin
      out_item_r <= '{hit: found_r, hit_x: hx_r, hit_y: hy_r};
    end
    case (state_r)
      rpnh_pkg::B_EDGE: begin
        if (step_r != '0) begin
          if (!kk[0]) begin
            acc_r <= AW'(prod_r);
          end else begin
            case (kk)
              3'd1:    den_r <= $signed(acc_r[CW-1:0]) - $signed(prod_r[CW-1:0]);
              3'd3:    un_r  <= $signed(acc_r[CW-1:0]) - $signed(prod_r[CW-1:0]);
              default: tn_r  <= $signed(acc_r[CW-1:0]) - $signed(prod_r[CW-1:0]);
            endcase
          end
        end
      end
      rpnh_pkg::B_NORM: begin
        den_r <= nd;
        un_r  <= nu;
        if (hit_ok && !found_r) begin
          bn_r <= nu[MW-1:0];
          bd_r <= nd[MW-1:0];
        end
      end
      rpnh_pkg::B_CMP: begin
        if (step_r == '0) begin
          acc_r <= '0;
        end else if (kk[2]) begin
          acc_r <= acc_r - term;
        end else begin
          acc_r <= acc_r + term;
        end
      end
      rpnh_pkg::B_DECIDE: begin
        if (acc_r[AW-1]) begin
          bn_r <= un_r[MW-1:0];
          bd_r <= den_r[MW-1:0];
        end
      end
      rpnh_pkg::B_FIN: begin
        coord_r <= 1'b0;
        if (!found_r) begin
          hx_r <= '0;
          hy_r <= '0;
        end
      end
      rpnh_pkg::B_PT: begin
        if (step_r == '0) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_r + term;
        end
      end
      rpnh_pkg::B_DIVSET: begin
        neg_r <= acc_r[AW-1];
        rem_r <= '0;
        quo_r <= mag_w[DW-1:0];
      end
      rpnh_pkg::B_DIV: begin
        rem_r <= div_ge ? MW'(div_sh - {1'b0, bd_r}) : div_sh[MW-1:0];
        quo_r <= {quo_r[DW-2:0], div_ge};
      end
      rpnh_pkg::B_SAT: begin
        if (coord_r) begin
          hy_r <= sat_v;
        end else begin
          hx_r <= sat_v;
        end
        coord_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_best_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r != rpnh_pkg::B_IDLE) |-> (bd_r != '0))
    else $error("best hit kept with zero denominator");
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == rpnh_pkg::B_EMIT))
    else $error("result posted outside emit");
  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpnh_pkg::B_DIV) |-> (step_r < SW'(DW)))
    else $error("divider ran past its length");
`endif

endmodule

>>> design/ray_polygon_nearest_hit_core.sv
// ----------------------------------------------------------------------------
// ray_polygon_nearest_hit_core
// Streams polygon vertices, tests each edge against the ray, reports nearest hit.
// ----------------------------------------------------------------------------
// Each edge is tested in the back end (shared 18x18 multiplier), and is further
// compared with the best hit so far when it hits and a best hit already exists.
// The closing vertex adds the hit point when a hit was found, one coordinate at a
// time (restoring divider, 61-bit quotient); then the result is emitted.
// A 4-deep edge job queue lets vertex transactions be accepted during that work.
// Synchronous active-low reset clears the polygon, queue and result state.
module ray_polygon_nearest_hit_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  rpnh_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output rpnh_pkg::out_item_t out_item
);

  rpnh_pkg::q_wr_ctl_t wr_ctl;
  rpnh_pkg::edge_job_t wr_job, rd_job;
  logic                q_push;
  logic                q_full, q_empty, q_pop;

  assign wr_ctl = '{push: q_push, full: q_full};

  rpnh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_push  (q_push),
    .q_job   (wr_job),
    .q_full  (q_full)
  );

  rpnh_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_ctl (wr_ctl),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  rpnh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (rd_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
